FILE: design/mtne_pkg.sv
// Package for the MIDI track note extractor.
// Holds the fixed field widths, the tempo and ticks-per-quarter reset values, the meta event bytes and the tone table.
// No dependencies.
package mtne_pkg;

  localparam int unsigned TpqWidth   = 15;
  localparam int unsigned ByteWidth  = 8;
  localparam int unsigned NoteWidth  = 7;
  localparam int unsigned ToneWidth  = 13;
  localparam int unsigned DurWidth   = 52;
  localparam int unsigned TempoWidth = 24;
  localparam int unsigned LenWidth   = 28;
  localparam int unsigned ToneCount  = 108;

  localparam logic [TpqWidth-1:0]   TpqReset   = 15'd96;
  localparam logic [TempoWidth-1:0] TempoReset = 24'd500000;

  localparam logic [ByteWidth-1:0] MetaStatus = 8'hFF;
  localparam logic [ByteWidth-1:0] MetaTempo  = 8'h51;

  localparam logic [ToneWidth-1:0] ToneTable [ToneCount] = '{
    13'd16, 13'd17, 13'd18, 13'd19, 13'd21, 13'd22, 13'd23, 13'd25, 13'd26,
    13'd28, 13'd29, 13'd31, 13'd33, 13'd35, 13'd37, 13'd39, 13'd41, 13'd44,
    13'd46, 13'd49, 13'd52, 13'd55, 13'd58, 13'd62, 13'd65, 13'd69, 13'd73,
    13'd78, 13'd82, 13'd87, 13'd93, 13'd98, 13'd104, 13'd110, 13'd117,
    13'd124, 13'd131, 13'd139, 13'd147, 13'd156, 13'd165, 13'd175, 13'd185,
    13'd196, 13'd208, 13'd220, 13'd233, 13'd247, 13'd262, 13'd277, 13'd294,
    13'd311, 13'd330, 13'd349, 13'd370, 13'd392, 13'd415, 13'd440, 13'd466,
    13'd493, 13'd523, 13'd554, 13'd587, 13'd622, 13'd659, 13'd699, 13'd740,
    13'd784, 13'd831, 13'd880, 13'd932, 13'd988, 13'd1047, 13'd1109,
    13'd1175, 13'd1245, 13'd1319, 13'd1397, 13'd1480, 13'd1568, 13'd1661,
    13'd1760, 13'd1865, 13'd1976, 13'd2093, 13'd2217, 13'd2349, 13'd2489,
    13'd2637, 13'd2794, 13'd2960, 13'd3136, 13'd3322, 13'd3520, 13'd3729,
    13'd3951, 13'd4186, 13'd4485, 13'd4699, 13'd4978, 13'd5274, 13'd5588,
    13'd5920, 13'd6272, 13'd6645, 13'd7040, 13'd7459, 13'd7902
  };

endpackage

FILE: design/mtne_byte_if.sv
// Valid/ready channel carrying one track data byte.
// Depends on mtne_pkg.
interface mtne_byte_if;
  logic                             valid;
  logic                             ready;
  logic [mtne_pkg::ByteWidth-1:0]   data_byte;

  modport source (output valid, output data_byte, input ready);
  modport sink   (input valid, input data_byte, output ready);
endinterface

FILE: design/mtne_note_if.sv
// Valid/ready channel carrying one finished-note or error result.
// Depends on mtne_pkg.
interface mtne_note_if;
  logic                             valid;
  logic                             ready;
  logic                             result_kind;
  logic [mtne_pkg::NoteWidth-1:0]   note_number;
  logic [mtne_pkg::ToneWidth-1:0]   tone_hz;
  logic [mtne_pkg::DurWidth-1:0]    duration_us;

  modport source (output valid, output result_kind, output note_number,
                  output tone_hz, output duration_us, input ready);
  modport sink   (input valid, input result_kind, input note_number,
                  input tone_hz, input duration_us, output ready);
endinterface

FILE: design/mtne_cfg_if.sv
// Configuration write channel: ticks per quarter note.
// Depends on mtne_pkg.
interface mtne_cfg_if;
  logic                             valid;
  logic                             ready;
  logic [mtne_pkg::TpqWidth-1:0]    ticks_per_quarter;

  modport source (output valid, output ticks_per_quarter, input ready);
  modport sink   (input valid, input ticks_per_quarter, output ready);
endinterface

FILE: design/mtne_muldiv.sv
// Sequential duration unit: delta * tempo by shift-add, then restoring
// division by ticks, both on one shared add/subtract unit. Saturates to 52 bits.
// Depends on mtne_pkg.
module mtne_muldiv #(
  parameter int unsigned DELTA_WIDTH = 28
) (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              start_i,
  input  logic [DELTA_WIDTH-1:0]            delta_i,
  input  logic [mtne_pkg::TempoWidth-1:0]   tempo_i,
  input  logic [mtne_pkg::TpqWidth-1:0]     tpq_i,
  output logic                              done_o,
  output logic [mtne_pkg::DurWidth-1:0]     dur_o
);

  localparam int unsigned TW  = mtne_pkg::TempoWidth;
  localparam int unsigned QW  = mtne_pkg::TpqWidth;
  localparam int unsigned DW  = mtne_pkg::DurWidth;
  localparam int unsigned PW  = DELTA_WIDTH + TW;
  localparam int unsigned AW  = TW + 1;
  localparam int unsigned CW  = $clog2(PW + 1);
  localparam int unsigned OW  = (PW > DW) ? PW : DW;
  localparam logic [OW-1:0] SatMax = {{(OW-DW){1'b0}}, {DW{1'b1}}};

  typedef enum logic [1:0] {
    S_IDLE,
    S_MUL,
    S_DIV,
    S_FIN
  } state_e;

  state_e          state_q;
  logic [PW-1:0]   p_q;
  logic [TW-1:0]   tempo_q;
  logic [QW-1:0]   tpq_q;
  logic [QW-1:0]   rem_q;
  logic [CW-1:0]   cnt_q;
  logic            done_q;
  logic [DW-1:0]   dur_q;

  // shared add/subtract unit
  logic            alu_sub;
  logic [AW-1:0]   alu_a;
  logic [AW-1:0]   alu_b;
  logic [AW:0]     alu_res;

  logic [QW:0]     div_t;
  logic            borrow;
  logic [AW-1:0]   mul_hi;
  logic [OW-1:0]   q_ext;

  assign div_t   = {rem_q, p_q[PW-1]};
  assign alu_sub = (state_q == S_DIV);
  assign alu_a   = alu_sub ? AW'(div_t) : {1'b0, p_q[PW-1:DELTA_WIDTH]};
  assign alu_b   = alu_sub ? AW'(tpq_q) : {1'b0, tempo_q};
  assign alu_res = alu_sub ? ({1'b0, alu_a} - {1'b0, alu_b})
                           : ({1'b0, alu_a} + {1'b0, alu_b});
  assign borrow  = alu_res[AW];
  assign mul_hi  = p_q[0] ? alu_res[AW-1:0] : {1'b0, p_q[PW-1:DELTA_WIDTH]};
  assign q_ext   = OW'(p_q);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
      done_q  <= 1'b0;
      cnt_q   <= '0;
      p_q     <= '0;
      tempo_q <= '0;
      tpq_q   <= '0;
      rem_q   <= '0;
      dur_q   <= '0;
    end else begin
      done_q <= (state_q == S_FIN);
      case (state_q)
        S_IDLE: begin
          if (start_i) begin
            p_q     <= {{TW{1'b0}}, delta_i};
            tempo_q <= tempo_i;
            tpq_q   <= (tpq_i == '0) ? QW'(1) : tpq_i;
            rem_q   <= '0;
            cnt_q   <= CW'(DELTA_WIDTH);
            state_q <= S_MUL;
          end
        end
        S_MUL: begin
          p_q <= {mul_hi, p_q[DELTA_WIDTH-1:1]};
          if (cnt_q == CW'(1)) begin
            cnt_q   <= CW'(PW);
            state_q <= S_DIV;
          end else begin
            cnt_q <= cnt_q - 1'b1;
          end
        end
        S_DIV: begin
          p_q   <= {p_q[PW-2:0], ~borrow};
          rem_q <= borrow ? div_t[QW-1:0] : alu_res[QW-1:0];
          cnt_q <= cnt_q - 1'b1;
          if (cnt_q == CW'(1)) begin
            state_q <= S_FIN;
          end
        end
        S_FIN: begin
          dur_q   <= (q_ext > SatMax) ? {DW{1'b1}} : q_ext[DW-1:0];
          state_q <= S_IDLE;
        end
        default: state_q <= S_IDLE;
      endcase
    end
  end

  assign done_o = done_q;
  assign dur_o  = dur_q;

endmodule

FILE: design/midi_track_note_extractor.sv
// MIDI track note extractor. Parses track bytes and reports finished notes.
// data_i (sink) takes one track byte per transfer; cfg_i writes ticks per
// quarter note (reset 96, zero is treated as one) and is always ready.
// note_o (source) carries one result: a finished note with its key, table
// tone and duration in microseconds, or an overlap error after which all
// further bytes are dropped until reset.
// Most bytes leave data_i ready again the cycle after a transfer.
// A note-off status byte starts the duration unit, a shift-add multiply over
// the delta bits followed by a restoring divide over the product bits on one
// adder; data_i stays low, for this and for an error result, until the
// result is loaded into the output register, where it sits; a stalled
// receiver lets the block keep parsing bytes, and it stalls only when a
// second result is ready before the first has been taken.
// Reset clears the parser, tempo (500000 us), last command and halt flag.
// Depends on mtne_pkg, mtne_byte_if, mtne_note_if, mtne_cfg_if, mtne_muldiv.
module midi_track_note_extractor #(
  parameter int unsigned DELTA_WIDTH     = 28,
  parameter int unsigned TONE_TABLE_SIZE = 108
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  mtne_byte_if.sink        data_i,
  mtne_cfg_if.sink         cfg_i,
  mtne_note_if.source      note_o
);

  localparam int unsigned BW = mtne_pkg::ByteWidth;
  localparam int unsigned NW = mtne_pkg::NoteWidth;
  localparam int unsigned LW = mtne_pkg::LenWidth;
  localparam int unsigned TW = mtne_pkg::TempoWidth;
  localparam int unsigned ToneTop =
    (TONE_TABLE_SIZE > mtne_pkg::ToneCount) ? mtne_pkg::ToneCount :
    ((TONE_TABLE_SIZE < 1) ? 1 : TONE_TABLE_SIZE);
  localparam logic [NW-1:0] ToneLast = NW'(ToneTop - 1);

  typedef enum logic [1:0] {
    S_IDLE,
    S_CALC,
    S_EMIT
  } state_e;

  typedef enum logic [2:0] {
    PH_DELTA,
    PH_STATUS,
    PH_SKIP1,
    PH_SKIP2,
    PH_KEY,
    PH_MTYPE,
    PH_MLEN,
    PH_MBODY
  } phase_e;

  typedef enum logic [1:0] {
    CMD_NONE,
    CMD_ON,
    CMD_OFF
  } cmd_e;

  state_e                        state_q;
  phase_e                        phase_q;
  cmd_e                          last_cmd_q;
  logic                          halted_q;
  logic [DELTA_WIDTH-1:0]        delta_q;
  logic [LW-1:0]                 len_q;
  logic [BW-1:0]                 meta_kind_q;
  logic [TW-1:0]                 tempo_q;
  logic [NW-1:0]                 held_q;
  logic [mtne_pkg::TpqWidth-1:0] tpq_q;
  logic                          pend_err_q;

  logic                          out_valid_q;
  logic                          out_kind_q;
  logic [NW-1:0]                 out_note_q;
  logic [mtne_pkg::ToneWidth-1:0] out_tone_q;
  logic [mtne_pkg::DurWidth-1:0] out_dur_q;

  logic                          in_xfer;
  logic [BW-1:0]                 b;
  logic [DELTA_WIDTH+6:0]        delta_shift;
  logic [LW+6:0]                 len_shift;
  logic [LW-1:0]                 len_next;
  logic [NW-1:0]                 tone_idx;
  logic                          is_off_start;
  logic                          md_done;
  logic [mtne_pkg::DurWidth-1:0] md_dur;
  logic                          out_free;

  assign data_i.ready = (state_q == S_IDLE);
  assign cfg_i.ready  = 1'b1;
  assign in_xfer      = data_i.valid && data_i.ready;
  assign b            = data_i.data_byte;
  assign delta_shift  = {delta_q, b[6:0]};
  assign len_shift    = {len_q, b[6:0]};
  assign len_next     = len_shift[LW-1:0];
  assign tone_idx     = (held_q > ToneLast) ? ToneLast : held_q;
  assign out_free     = !out_valid_q || note_o.ready;

  // note-off status with no prior note-off starts the duration unit
  assign is_off_start = in_xfer && !halted_q && (phase_q == PH_STATUS) &&
                        (b[7:4] == 4'h8) && (last_cmd_q != CMD_OFF);

  mtne_muldiv #(
    .DELTA_WIDTH (DELTA_WIDTH)
  ) u_muldiv (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (is_off_start),
    .delta_i (delta_q),
    .tempo_i (tempo_q),
    .tpq_i   (tpq_q),
    .done_o  (md_done),
    .dur_o   (md_dur)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      tpq_q <= mtne_pkg::TpqReset;
    end else if (cfg_i.valid) begin
      tpq_q <= cfg_i.ticks_per_quarter;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      phase_q     <= PH_DELTA;
      last_cmd_q  <= CMD_NONE;
      halted_q    <= 1'b0;
      delta_q     <= '0;
      len_q       <= '0;
      meta_kind_q <= '0;
      tempo_q     <= mtne_pkg::TempoReset;
      held_q      <= '0;
      pend_err_q  <= 1'b0;
      out_valid_q <= 1'b0;
      out_kind_q  <= 1'b0;
      out_note_q  <= '0;
      out_tone_q  <= '0;
      out_dur_q   <= '0;
    end else begin
      if ((state_q == S_EMIT) && out_free) begin
        out_valid_q <= 1'b1;
      end else if (note_o.valid && note_o.ready) begin
        out_valid_q <= 1'b0;
      end
      case (state_q)
        S_IDLE: begin
          if (in_xfer && !halted_q) begin
            case (phase_q)
              PH_DELTA: begin
                delta_q <= delta_shift[DELTA_WIDTH-1:0];
                if (!b[7]) phase_q <= PH_STATUS;
              end
              PH_STATUS: begin
                if (b == mtne_pkg::MetaStatus) begin
                  phase_q <= PH_MTYPE;
                end else if (b[7:5] == 3'b110) begin
                  phase_q <= PH_SKIP1;
                end else if (b[7:4] == 4'h9) begin
                  if (last_cmd_q == CMD_ON) begin
                    halted_q   <= 1'b1;
                    pend_err_q <= 1'b1;
                    state_q    <= S_EMIT;
                  end else begin
                    last_cmd_q <= CMD_ON;
                    phase_q    <= PH_KEY;
                  end
                end else if (b[7:4] == 4'h8) begin
                  if (last_cmd_q == CMD_OFF) begin
                    halted_q   <= 1'b1;
                    pend_err_q <= 1'b1;
                    state_q    <= S_EMIT;
                  end else begin
                    last_cmd_q <= CMD_OFF;
                    pend_err_q <= 1'b0;
                    phase_q    <= PH_SKIP2;
                    state_q    <= S_CALC;
                  end
                end else begin
                  phase_q <= PH_SKIP2;
                end
              end
              PH_KEY: begin
                held_q  <= b[NW-1:0];
                phase_q <= PH_SKIP1;
              end
              PH_SKIP2: phase_q <= PH_SKIP1;
              PH_SKIP1: begin
                phase_q <= PH_DELTA;
                delta_q <= '0;
              end
              PH_MTYPE: begin
                meta_kind_q <= b;
                len_q       <= '0;
                phase_q     <= PH_MLEN;
              end
              PH_MLEN: begin
                len_q <= len_next;
                if (!b[7]) begin
                  if (len_next == '0) begin
                    phase_q <= PH_DELTA;
                    delta_q <= '0;
                  end else begin
                    phase_q <= PH_MBODY;
                  end
                end
              end
              PH_MBODY: begin
                if (meta_kind_q == mtne_pkg::MetaTempo) begin
                  tempo_q <= {tempo_q[TW-BW-1:0], b};
                end
                len_q <= len_q - 1'b1;
                if (len_q == LW'(1)) begin
                  phase_q <= PH_DELTA;
                  delta_q <= '0;
                end
              end
              default: begin
                phase_q <= PH_DELTA;
                delta_q <= '0;
              end
            endcase
          end
        end
        S_CALC: begin
          if (md_done) state_q <= S_EMIT;
        end
        S_EMIT: begin
          if (out_free) begin
            out_kind_q  <= pend_err_q;
            out_note_q  <= pend_err_q ? '0 : held_q;
            out_tone_q  <= pend_err_q ? '0 : mtne_pkg::ToneTable[tone_idx];
            out_dur_q   <= pend_err_q ? '0 : md_dur;
            state_q     <= S_IDLE;
          end
        end
        default: state_q <= S_IDLE;
      endcase
    end
  end

  assign note_o.valid       = out_valid_q;
  assign note_o.result_kind = out_kind_q;
  assign note_o.note_number = out_note_q;
  assign note_o.tone_hz     = out_tone_q;
  assign note_o.duration_us = out_dur_q;

endmodule
